[design/shpd_pkg.sv]
// shared types and constants of the sensor hub packet deframer
package shpd_pkg;

    localparam int PADDR_W = 4;

    localparam logic [14:0] HDR_BYTES       = 15'd4;
    localparam logic [14:0] PID_MIN_PAYLOAD = 15'd8;
    localparam logic [7:0]  CTRL_CHANNEL    = 8'd2;
    localparam logic [7:0]  PID_RESPONSE    = 8'hF8;
    localparam logic [7:0]  LEN_ALL_ONES    = 8'hFF;

    localparam logic [14:0] MAX_PACKET_LEN_RST  = 15'd512;
    localparam logic [8:0]  CHANNEL_COUNT_RST   = 9'd6;
    localparam logic [31:0] EXPECTED_PID_RST    = 32'd10004148;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_KEPT    = 3'd1,
        KIND_DRAINED = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_INVALID = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_MAX_PACKET_LEN = 2'd0,
        REG_CHANNEL_COUNT  = 2'd1,
        REG_EXPECTED_PID   = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [14:0] max_packet_len;
        logic [8:0]  channel_count;
        logic [31:0] expected_product_id;
    } shpd_cfg_t;

endpackage

[design/shpd_if.sv]
// byte input and result output channel interfaces
interface shpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface shpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [14:0] payload_index;
    logic [7:0]  channel_number;
    logic [14:0] payload_length;
    logic        packet_done;
    logic [7:0]  report_id;
    logic [31:0] product_id;
    logic        id_valid;
    logic        id_match;
    logic        link_ok;
    logic [15:0] packets_received;

    modport source (
        output valid, input ready,
        output kind, output data_byte, output payload_index, output channel_number,
        output payload_length, output packet_done, output report_id, output product_id,
        output id_valid, output id_match, output link_ok,
        output packets_received
    );
    modport sink (
        input valid, output ready,
        input kind, input data_byte, input payload_index, input channel_number,
        input payload_length, input packet_done, input report_id, input product_id,
        input id_valid, input id_match, input link_ok,
        input packets_received
    );
endinterface

[design/shpd_cfg_regs.sv]
// apb configuration registers of the deframer
module shpd_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shpd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output shpd_pkg::shpd_cfg_t          cfg
);
    import shpd_pkg::*;

    shpd_cfg_t cfg_reg;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_packet_len      <= MAX_PACKET_LEN_RST;
            cfg_reg.channel_count       <= CHANNEL_COUNT_RST;
            cfg_reg.expected_product_id <= EXPECTED_PID_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_PACKET_LEN: cfg_reg.max_packet_len      <= pwdata[14:0];
                REG_CHANNEL_COUNT:  cfg_reg.channel_count       <= pwdata[8:0];
                REG_EXPECTED_PID:   cfg_reg.expected_product_id <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_PACKET_LEN: prdata = {17'd0, cfg_reg.max_packet_len};
            REG_CHANNEL_COUNT:  prdata = {23'd0, cfg_reg.channel_count};
            REG_EXPECTED_PID:   prdata = cfg_reg.expected_product_id;
            default:            prdata = 32'd0;
        endcase
    end

endmodule

[design/shpd_deframe_core.sv]
// packet deframing state, diagnostics and result register
module shpd_deframe_core #(
    parameter int KEPT_PAYLOAD_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shpd_pkg::shpd_cfg_t cfg,
    shpd_in_if.sink             rx,
    shpd_out_if.source          res
);
    import shpd_pkg::*;

    localparam logic [14:0] KEPT_LIMIT = 15'(KEPT_PAYLOAD_BYTES);

    logic [14:0] pos_reg, pos_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [14:0] pkt_len_reg, pkt_len_next;
    logic [7:0]  chan_reg, chan_next;
    logic [7:0]  report_reg, report_next;
    logic [31:0] id_asm_reg, id_asm_next;
    logic [31:0] latched_id_reg, latched_id_next;
    logic        pid_valid_reg, pid_valid_next;
    logic        pid_match_reg, pid_match_next;
    logic        link_ok_reg, link_ok_next;
    logic [7:0]  last_report_reg, last_report_next;
    logic [15:0] pkt_count_reg, pkt_count_next;

    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [7:0]  data_reg;
    logic [14:0] pidx_reg, pidx_next;
    logic [7:0]  ochan_reg, ochan_next;
    logic [14:0] oplen_reg, oplen_next;
    logic        done_reg, done_next;

    logic        accept;
    logic [7:0]  b;
    logic [14:0] pidx_w;
    logic [14:0] plen_w;
    logic        last_byte;

    assign rx.ready = !out_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;
    assign pidx_w   = pos_reg - HDR_BYTES;
    assign plen_w   = pkt_len_reg - HDR_BYTES;
    assign last_byte = ({1'b0, pos_reg} + 16'd1) >= {1'b0, pkt_len_reg};

    always_comb
    begin
        pos_next         = pos_reg;
        len_low_next     = len_low_reg;
        pkt_len_next     = pkt_len_reg;
        chan_next        = chan_reg;
        report_next      = report_reg;
        id_asm_next      = id_asm_reg;
        latched_id_next  = latched_id_reg;
        pid_valid_next   = pid_valid_reg;
        pid_match_next   = pid_match_reg;
        link_ok_next     = link_ok_reg;
        last_report_next = last_report_reg;
        pkt_count_next   = pkt_count_reg;
        kind_next        = KIND_HEADER;
        pidx_next        = 15'd0;
        ochan_next       = 8'd0;
        oplen_next       = 15'd0;
        done_next        = 1'b0;

        unique case (pos_reg)
            15'd0:
            begin
                len_low_next = b;
                pos_next     = 15'd1;
            end
            15'd1:
            begin
                pkt_len_next = {b[6:0], len_low_reg};
                len_low_next = b;
                pos_next     = 15'd2;
            end
            15'd2:
            begin
                chan_next  = b;
                ochan_next = b;
                pos_next   = 15'd3;
            end
            15'd3:
            begin
                pos_next = 15'd0;
                if (pkt_len_reg[7:0] == LEN_ALL_ONES && len_low_reg == LEN_ALL_ONES)
                begin
                    kind_next = KIND_EMPTY;
                end
                else if (pkt_len_reg < HDR_BYTES || pkt_len_reg > cfg.max_packet_len
                         || {1'b0, chan_reg} >= cfg.channel_count)
                begin
                    kind_next  = KIND_INVALID;
                    ochan_next = chan_reg;
                end
                else
                begin
                    ochan_next  = chan_reg;
                    oplen_next  = plen_w;
                    report_next = 8'd0;
                    id_asm_next = 32'd0;
                    if (plen_w == 15'd0)
                        done_next = 1'b1;
                    else
                        pos_next = HDR_BYTES;
                end
            end
            default:
            begin
                pidx_next  = pidx_w;
                ochan_next = chan_reg;
                oplen_next = plen_w;
                kind_next  = (pidx_w < KEPT_LIMIT) ? KIND_KEPT : KIND_DRAINED;
                if (pidx_w == 15'd0)
                    report_next = b;
                if (pidx_w[14:3] == 12'd0 && pidx_w[2])
                    id_asm_next = id_asm_reg | (32'(b) << {pidx_w[1:0], 3'b000});
                if (last_byte)
                begin
                    done_next        = 1'b1;
                    pos_next         = 15'd0;
                    pkt_count_next   = pkt_count_reg + 16'd1;
                    last_report_next = report_next;
                    if (chan_reg == CTRL_CHANNEL && report_next == PID_RESPONSE)
                    begin
                        if (plen_w >= PID_MIN_PAYLOAD)
                        begin
                            latched_id_next = id_asm_next;
                            pid_valid_next  = 1'b1;
                            pid_match_next  = (id_asm_next == cfg.expected_product_id);
                        end
                        link_ok_next = 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 15'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 15'd0;
            len_low_reg     <= 8'd0;
            pkt_len_reg     <= 15'd0;
            chan_reg        <= 8'd0;
            report_reg      <= 8'd0;
            id_asm_reg      <= 32'd0;
            latched_id_reg  <= 32'd0;
            pid_valid_reg   <= 1'b0;
            pid_match_reg   <= 1'b0;
            link_ok_reg     <= 1'b0;
            last_report_reg <= 8'd0;
            pkt_count_reg   <= 16'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg         <= pos_next;
                len_low_reg     <= len_low_next;
                pkt_len_reg     <= pkt_len_next;
                chan_reg        <= chan_next;
                report_reg      <= report_next;
                id_asm_reg      <= id_asm_next;
                latched_id_reg  <= latched_id_next;
                pid_valid_reg   <= pid_valid_next;
                pid_match_reg   <= pid_match_next;
                link_ok_reg     <= link_ok_next;
                last_report_reg <= last_report_next;
                pkt_count_reg   <= pkt_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_next;
            data_reg  <= b;
            pidx_reg  <= pidx_next;
            ochan_reg <= ochan_next;
            oplen_reg <= oplen_next;
            done_reg  <= done_next;
        end
    end

    // status fields only change on a transfer, so they track the held result
    assign res.valid            = out_valid_reg;
    assign res.kind             = kind_reg;
    assign res.data_byte        = data_reg;
    assign res.payload_index    = pidx_reg;
    assign res.channel_number   = ochan_reg;
    assign res.payload_length   = oplen_reg;
    assign res.packet_done      = done_reg;
    assign res.report_id        = last_report_reg;
    assign res.product_id       = latched_id_reg;
    assign res.id_valid         = pid_valid_reg;
    assign res.id_match         = pid_match_reg;
    assign res.link_ok          = link_ok_reg;
    assign res.packets_received = pkt_count_reg;

endmodule

[design/sensor_hub_packet_deframer.sv]
// top level of the sensor hub packet deframer
// result: registered, valid in the cycle after its byte transfer
// throughput: one byte per cycle while the result sink is ready
// the result register frees in the same cycle it is taken, so input and output overlap
// reset: rst_n clears deframing state, diagnostics and counters; registers return
// to their reset values, except the unreset result payload; no clearing pass
module sensor_hub_packet_deframer #(
    parameter int KEPT_PAYLOAD_BYTES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [shpd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    shpd_in_if.sink                      rx,
    shpd_out_if.source                   res
);
    import shpd_pkg::*;

    shpd_cfg_t cfg;

    shpd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    shpd_deframe_core #(
        .KEPT_PAYLOAD_BYTES (KEPT_PAYLOAD_BYTES)
    ) u_deframe_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );

endmodule

[tb/shpd_checker.sv]
`timescale 1ns / 1ps
// scoreboard that predicts every deframer result and compares it with the block's output
module shpd_checker #(
    parameter int KEPT_PAYLOAD_BYTES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [shpd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    shpd_in_if                           rx_mon,
    shpd_out_if                          res_mon,
    output int unsigned                  pending_results,
    output int unsigned                  error_count
);
    import shpd_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [14:0] payload_index;
        logic [7:0]  channel_number;
        logic [14:0] payload_length;
        logic        packet_done;
        logic [7:0]  report_id;
        logic [31:0] product_id;
        logic        id_valid;
        logic        id_match;
        logic        link_ok;
        logic [15:0] packets_received;
    } deframe_result_t;

    deframe_result_t predicted_results[$];
    int unsigned     result_no;

    logic [14:0] cfg_max_len;
    logic [8:0]  cfg_chan_count;
    logic [31:0] cfg_expected_pid;

    logic [14:0] frame_pos;
    logic [7:0]  len_byte_seen;
    logic [14:0] frame_len;
    logic [7:0]  frame_chan;
    logic [7:0]  rpt_first;
    logic [31:0] id_acc;
    logic [31:0] id_latched;
    logic        pid_valid;
    logic        pid_match;
    logic        link_up;
    logic [7:0]  rpt_last;
    logic [15:0] pkt_count;

    function automatic void retire_packet();
        logic [14:0] body_len;
        body_len = frame_len - HDR_BYTES;
        if (body_len != 15'd0)
        begin
            pkt_count = pkt_count + 16'd1;
            rpt_last  = rpt_first;
            if (frame_chan == CTRL_CHANNEL && rpt_first == PID_RESPONSE)
            begin
                if (body_len >= PID_MIN_PAYLOAD)
                begin
                    id_latched = id_acc;
                    pid_valid  = 1'b1;
                    pid_match  = (id_acc == cfg_expected_pid);
                end
                link_up = 1'b1;
            end
        end
    endfunction

    function automatic deframe_result_t deframe_byte(input logic [7:0] b);
        deframe_result_t r;
        logic [14:0]     idx;
        r           = '0;
        r.kind      = KIND_HEADER;
        r.data_byte = b;
        if (frame_pos == 15'd0)
        begin
            len_byte_seen = b;
            frame_pos     = 15'd1;
        end
        else if (frame_pos == 15'd1)
        begin
            frame_len     = {b[6:0], len_byte_seen};
            len_byte_seen = b;
            frame_pos     = 15'd2;
        end
        else if (frame_pos == 15'd2)
        begin
            frame_chan       = b;
            r.channel_number = b;
            frame_pos        = 15'd3;
        end
        else if (frame_pos == 15'd3)
        begin
            frame_pos = 15'd0;
            if (frame_len[7:0] == LEN_ALL_ONES && len_byte_seen == LEN_ALL_ONES)
            begin
                r.kind = KIND_EMPTY;
            end
            else if (frame_len < HDR_BYTES || frame_len > cfg_max_len
                     || {1'b0, frame_chan} >= cfg_chan_count)
            begin
                r.kind           = KIND_INVALID;
                r.channel_number = frame_chan;
            end
            else
            begin
                r.channel_number = frame_chan;
                r.payload_length = frame_len - HDR_BYTES;
                rpt_first        = 8'd0;
                id_acc           = 32'd0;
                if (r.payload_length == 15'd0)
                begin
                    r.packet_done = 1'b1;
                    retire_packet();
                end
                else
                begin
                    frame_pos = HDR_BYTES;
                end
            end
        end
        else
        begin
            idx              = frame_pos - HDR_BYTES;
            r.payload_index  = idx;
            r.channel_number = frame_chan;
            r.payload_length = frame_len - HDR_BYTES;
            r.kind           = (int'(idx) < KEPT_PAYLOAD_BYTES) ? KIND_KEPT : KIND_DRAINED;
            if (idx == 15'd0)
                rpt_first = b;
            if (idx >= 15'd4 && idx < 15'd8)
                id_acc = id_acc | (32'(b) << (8 * (idx - 15'd4)));
            if ({1'b0, frame_pos} + 16'd1 >= {1'b0, frame_len})
            begin
                r.packet_done = 1'b1;
                frame_pos     = 15'd0;
                retire_packet();
            end
            else
            begin
                frame_pos = frame_pos + 15'd1;
            end
        end
        r.report_id        = rpt_last;
        r.product_id       = id_latched;
        r.id_valid         = pid_valid;
        r.id_match         = pid_match;
        r.link_ok          = link_up;
        r.packets_received = pkt_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        deframe_result_t seen;
        deframe_result_t want;
        if (!rst_n)
        begin
            predicted_results.delete();
            pending_results  = 0;
            error_count      = 0;
            result_no        = 0;
            cfg_max_len      = MAX_PACKET_LEN_RST;
            cfg_chan_count   = CHANNEL_COUNT_RST;
            cfg_expected_pid = EXPECTED_PID_RST;
            frame_pos        = '0;
            len_byte_seen    = '0;
            frame_len        = '0;
            frame_chan       = '0;
            rpt_first        = '0;
            id_acc           = '0;
            id_latched       = '0;
            pid_valid        = 1'b0;
            pid_match        = 1'b0;
            link_up          = 1'b0;
            rpt_last         = '0;
            pkt_count        = '0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                seen.kind             = kind_t'(res_mon.kind);
                seen.data_byte        = res_mon.data_byte;
                seen.payload_index    = res_mon.payload_index;
                seen.channel_number   = res_mon.channel_number;
                seen.payload_length   = res_mon.payload_length;
                seen.packet_done      = res_mon.packet_done;
                seen.report_id        = res_mon.report_id;
                seen.product_id       = res_mon.product_id;
                seen.id_valid         = res_mon.id_valid;
                seen.id_match         = res_mon.id_match;
                seen.link_ok          = res_mon.link_ok;
                seen.packets_received = res_mon.packets_received;
                if (predicted_results.size() == 0)
                begin
                    if (error_count < 10)
                        $display("result %0d arrived with nothing predicted: kind %0d byte %h",
                                 result_no, seen.kind, seen.data_byte);
                    error_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (seen !== want)
                    begin
                        if (error_count < 10)
                        begin
                            $display("result %0d mismatch (expected/actual): kind %0d/%0d",
                                     result_no, want.kind, seen.kind,
                                     " byte %h/%h index %0d/%0d chan %0d/%0d len %0d/%0d",
                                     want.data_byte, seen.data_byte,
                                     want.payload_index, seen.payload_index,
                                     want.channel_number, seen.channel_number,
                                     want.payload_length, seen.payload_length);
                            $display("  done %b/%b report %h/%h id %h/%h",
                                     want.packet_done, seen.packet_done,
                                     want.report_id, seen.report_id,
                                     want.product_id, seen.product_id,
                                     " valid %b/%b match %b/%b link %b/%b count %0d/%0d",
                                     want.id_valid, seen.id_valid,
                                     want.id_match, seen.id_match,
                                     want.link_ok, seen.link_ok,
                                     want.packets_received, seen.packets_received);
                        end
                        error_count++;
                    end
                end
                result_no++;
            end
            if (rx_mon.valid && rx_mon.ready)
                predicted_results.push_back(deframe_byte(rx_mon.rx_byte));
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_MAX_PACKET_LEN: cfg_max_len      = pwdata[14:0];
                    REG_CHANNEL_COUNT:  cfg_chan_count   = pwdata[8:0];
                    REG_EXPECTED_PID:   cfg_expected_pid = pwdata;
                    default: ;
                endcase
            end
            pending_results = predicted_results.size();
        end
    end

endmodule

[tb/sensor_hub_packet_deframer_tb.sv]
`timescale 1ns / 1ps
// top of the deframer testbench: clock, reset, register setup, byte traffic and verdict
module sensor_hub_packet_deframer_tb;
    import shpd_pkg::*;

    localparam int          KEPT_BYTES  = 64;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    int unsigned          results_outstanding;
    int unsigned          failures;
    int unsigned          bytes_sent;
    int unsigned          cycles;
    int unsigned          send_idle_pct;
    int unsigned          stall_pct;
    int unsigned          cfg_max;
    int unsigned          cfg_chans;
    logic [31:0]          cfg_pid;

    shpd_in_if  rx_if ();
    shpd_out_if res_if ();

    sensor_hub_packet_deframer #(
        .KEPT_PAYLOAD_BYTES(KEPT_BYTES)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rx      (rx_if),
        .res     (res_if)
    );

    shpd_checker #(
        .KEPT_PAYLOAD_BYTES(KEPT_BYTES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .rx_mon          (rx_if),
        .res_mon         (res_if),
        .pending_results (results_outstanding),
        .error_count     (failures)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result sink stalls
    always @(negedge clk)
    begin
        if (rst_n)
            res_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input int unsigned max_len, input int unsigned chans,
                                  input logic [31:0] pid);
        write_reg(REG_MAX_PACKET_LEN, max_len);
        write_reg(REG_CHANNEL_COUNT, chans);
        write_reg(REG_EXPECTED_PID, pid);
        cfg_max   = max_len;
        cfg_chans = chans;
        cfg_pid   = pid;
    endtask

    // one byte transfer, entered and left at a falling edge
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(negedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet(input int unsigned plen, input logic [7:0] ch,
                               input bit pid_resp, input logic [31:0] pid_val);
        logic [14:0] len;
        logic [7:0]  b;
        len = 15'(plen + 4);
        put_byte(len[7:0]);
        put_byte({(len == 15'h7FFF) ? 1'b0 : 1'($urandom_range(1)), len[14:8]});
        put_byte(ch);
        put_byte(8'($urandom));
        for (int unsigned i = 0; i < plen; i++)
        begin
            b = 8'($urandom);
            if (pid_resp && i == 0)
                b = PID_RESPONSE;
            if (pid_resp && i >= 4 && i < 8)
                b = 8'(pid_val >> (8 * (i - 4)));
            put_byte(b);
        end
    endtask

    task automatic send_random_traffic(input int unsigned count);
        int unsigned goal;
        int unsigned sel;
        int unsigned cap;
        int unsigned plen;
        int unsigned len;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  ch;
        bit          can_frame;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
        begin
            sel       = $urandom_range(99);
            cap       = (cfg_max >= 4) ? cfg_max - 4 : 0;
            can_frame = (cfg_max >= 4) && (cfg_chans != 0);
            lo        = 8'($urandom);
            hi        = 8'($urandom);
            ch        = 8'($urandom);
            if (can_frame && sel < 20 && cfg_chans > CTRL_CHANNEL && cap != 0)
            begin
                // product id response, sometimes too short to carry the id
                plen = ($urandom_range(3) == 0) ? $urandom_range(7, 1) : $urandom_range(16, 8);
                if (plen > cap)
                    plen = cap;
                send_packet(plen, CTRL_CHANNEL, 1'b1, $urandom_range(1) ? cfg_pid : $urandom);
            end
            else if (can_frame && sel < 70)
            begin
                sel = $urandom_range(9);
                plen = (sel < 5) ? $urandom_range(12)
                     : (sel < 8) ? $urandom_range(72, 56) : $urandom_range(300);
                if (plen > cap)
                    plen = cap;
                send_packet(plen, 8'($urandom_range(cfg_chans - 1)), 1'b0, '0);
            end
            else if (sel < 80)
            begin
                put_byte(LEN_ALL_ONES);
                put_byte(LEN_ALL_ONES);
                put_byte(ch);
                put_byte(8'($urandom));
            end
            else if (sel < 95)
            begin
                sel = $urandom_range(2);
                if (sel == 1 && cfg_max < 32767)
                begin
                    len = $urandom_range(32767, cfg_max + 1);
                    lo  = len[7:0];
                    hi  = {(len == 32767) ? 1'b0 : hi[7], len[14:8]};
                end
                else if (sel == 2 && cfg_chans < 256)
                begin
                    ch = 8'($urandom_range(255, cfg_chans));
                    if (lo == LEN_ALL_ONES && hi == LEN_ALL_ONES)
                        lo = 8'h00;
                end
                else
                begin
                    lo = 8'($urandom_range(3));
                    hi = {hi[7], 7'h00};
                end
                put_byte(lo);
                put_byte(hi);
                put_byte(ch);
                put_byte(8'($urandom));
            end
            else
            begin
                // arbitrary header, then whatever body it implies
                if (cfg_max > 1024)
                    hi[6:2] = '0;
                put_byte(lo);
                put_byte(hi);
                put_byte(ch);
                put_byte(8'($urandom));
                len = {hi[6:0], lo};
                if (!(lo == LEN_ALL_ONES && hi == LEN_ALL_ONES) && len >= 4
                    && len <= cfg_max && ch < cfg_chans)
                    repeat (len - 4) put_byte(8'($urandom));
            end
        end
    endtask

    task automatic drain_results();
        rx_if.valid <= 1'b0;
        while (results_outstanding != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rx_if.valid    = 1'b0;
        rx_if.rx_byte  = '0;
        res_if.ready   = 1'b0;
        bytes_sent     = 0;
        cycles         = 0;
        cfg_max        = MAX_PACKET_LEN_RST;
        cfg_chans      = CHANNEL_COUNT_RST;
        cfg_pid        = EXPECTED_PID_RST;
        send_idle_pct  = 37;
        stall_pct      = 52;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // product id response carrying the expected id
        send_packet(8, CTRL_CHANNEL, 1'b1, EXPECTED_PID_RST);
        // empty read
        put_byte(8'hFF);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h00);
        // masked length too short, all-ones channel
        put_byte(8'h03);
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(8'hFF);
        // empty payload on the highest valid channel
        put_byte(8'h04);
        put_byte(8'h00);
        put_byte(8'h05);
        put_byte(8'h7F);
        send_random_traffic(300);
        drain_results();

        apply_settings(32767, 256, $urandom);
        send_random_traffic(300);
        drain_results();

        send_idle_pct = 52;
        stall_pct     = 37;
        apply_settings(4, 1, 32'h0);
        send_random_traffic(250);
        drain_results();

        apply_settings(3, 0, 32'hFFFF_FFFF);
        send_random_traffic(150);
        drain_results();

        send_idle_pct = 0;
        stall_pct     = 0;
        apply_settings(100, 3, $urandom);
        send_random_traffic(300);
        drain_results();

        apply_settings(MAX_PACKET_LEN_RST, CHANNEL_COUNT_RST, EXPECTED_PID_RST);
        send_random_traffic(600);
        drain_results();
        repeat (4) @(negedge clk);

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/shpd_pkg.sv
design/shpd_if.sv
design/shpd_cfg_regs.sv
design/shpd_deframe_core.sv
design/sensor_hub_packet_deframer.sv
tb/shpd_checker.sv
tb/sensor_hub_packet_deframer_tb.sv
